[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CWK_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cwk assertion failed");
`define CWK_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("cwk forbidden condition seen");
`else
`define CWK_ASSERT(lbl, clk, rst, prop)
`define CWK_NEVER(lbl, clk, rst, cond)
`endif
`endif

[rtl/cwk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwk_pkg
// shared types, widths and constant tables of the wheel speed kinematics unit
// ----------------------------------------------------------------------------
package cwk_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 8;

  localparam int RW  = 35;   // rotated velocity, q16 mm/s
  localparam int PW  = 50;   // rotated x times omni sine
  localparam int TW  = 35;   // turning term, q16 mm/s
  localparam int SW  = 52;   // per-wheel linear sum
  localparam int VW  = 38;   // per-wheel speed, q16 mm/s
  localparam int FW  = 64;   // speed times gain

  localparam logic [1:0] REG_BASE_MODE = 2'd0;
  localparam logic [1:0] REG_RPM_GAIN  = 2'd1;
  localparam logic [1:0] REG_CENTER    = 2'd2;
  localparam logic [1:0] REG_HALF_PER  = 2'd3;

  localparam logic [23:0] RPM_GAIN_RST = 24'd12517;
  localparam logic [11:0] CENTER_RST   = 12'd542;
  localparam logic [12:0] HALF_PER_RST = 13'd1000;

  localparam int unsigned POLY_A = 102944;
  localparam int unsigned POLY_B = 42048;
  localparam int unsigned POLY_C = 4640;

  localparam logic signed [15:0] OMNI_SIN_Q16 = 16'sd28378;

  // floor(2^35 / 125), quotient may come out one low
  localparam logic [28:0] RECIP_125 = 29'd274877906;
  localparam int FRAC_N = 125;

  typedef logic [12:0] frac_tbl_t [FRAC_N];

  function automatic frac_tbl_t build_frac(input int unsigned scale);
    frac_tbl_t t;
    for (int i = 0; i < FRAC_N; i++) begin
      t[i] = 13'((i * scale + 125) / 250);
    end
    return t;
  endfunction

  localparam frac_tbl_t TURN_FRAC_OMNI = build_frac(16384);
  localparam frac_tbl_t TURN_FRAC_MEC  = build_frac(8192);

  typedef struct packed {
    logic                 mode;
    logic signed [RW-1:0] rvx;
    logic signed [RW-1:0] rvy;
    logic signed [PW-1:0] psin;
    logic signed [TW-1:0] turn;
  } cwk_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } cwk_qstat_t;

  typedef struct packed {
    logic       mode;
    logic [1:0] idx;
    logic       last;
  } cwk_meta_t;

endpackage

[rtl/cwk_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwk_front
// command intake: sine/cosine, frame rotation and turning term pipeline
// ----------------------------------------------------------------------------
module cwk_front import cwk_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] target_vx,
  input  logic signed [15:0] target_vy,
  input  logic signed [15:0] target_turn,
  input  logic [15:0]        heading,
  input  logic               base_mode,
  input  logic [11:0]        center_distance_mm,
  input  logic [12:0]        half_perimeter_mm,
  input  logic               pop,
  output logic               push,
  output cwk_item_t          item
);

  localparam int PH_UP = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;
  localparam int PH_DN = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
  localparam int ZUP   = (ANGLE_BITS <= 18) ? 18 - ANGLE_BITS : 0;
  localparam int ZDN   = (ANGLE_BITS > 18) ? ANGLE_BITS - 18 : 0;
  localparam logic [ANGLE_BITS-2:0] QLEN    = (ANGLE_BITS-1)'(1) << (ANGLE_BITS - 2);
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [16:0] quad_pos(input logic [ANGLE_BITS-1:0] ph);
    logic [ANGLE_BITS-2:0] r;
    r = {1'b0, ph[ANGLE_BITS-3:0]};
    if (ph[ANGLE_BITS-2]) begin
      r = QLEN - r;
    end
    return 17'((32'(r) << ZUP) >> ZDN);
  endfunction

  logic [CW-1:0] cnt;
  logic [8:0]    vld;
  logic          accept;
  logic [ANGLE_BITS-1:0] ph_s, ph_c;

  // stage payload
  logic signed [15:0] s1_vx, s1_vy, s1_w;
  logic [12:0]        s1_lev;
  logic [16:0]        s1_zs, s1_zc;
  logic               s1_ns, s1_nc;
  logic signed [15:0] s2_vx, s2_vy;
  logic [16:0]        s2_zs, s2_zc, s2_z2s, s2_z2c;
  logic               s2_ns, s2_nc;
  logic signed [29:0] s2_wl;
  logic signed [15:0] s3_vx, s3_vy;
  logic [16:0]        s3_zs, s3_zc, s3_z2s, s3_z2c;
  logic [15:0]        s3_t1s, s3_t1c;
  logic               s3_ns, s3_nc, s3_wneg;
  logic [27:0]        s3_m;
  logic signed [15:0] s4_vx, s4_vy;
  logic [16:0]        s4_zs, s4_zc, s4_ts, s4_tc;
  logic               s4_ns, s4_nc, s4_wneg;
  logic [27:0]        s4_m;
  logic [56:0]        s4_prod;
  logic signed [15:0] s5_vx, s5_vy;
  logic [16:0]        s5_sm, s5_cm;
  logic               s5_ns, s5_nc, s5_wneg;
  logic [21:0]        s5_a;
  logic [7:0]         s5_b;
  logic signed [15:0] s6_vx, s6_vy;
  logic signed [17:0] s6_s, s6_c;
  logic               s6_wneg;
  logic [21:0]        s6_a;
  logic [6:0]         s6_b;
  logic signed [33:0] s7_xc, s7_ys, s7_yc, s7_xs;
  logic               s7_wneg;
  logic [33:0]        s7_tmag;
  logic signed [RW-1:0] s8_rvx, s8_rvy;
  logic signed [TW-1:0] s8_turn;
  logic [8:1]         md;

  logic [21:0] a_est;
  logic [27:0] b_full;

  assign accept = start && !busy;
  assign busy   = (cnt == CW'(QUEUE_DEPTH));
  assign push   = vld[8];
  assign ph_s   = ANGLE_BITS'((32'(heading) << PH_UP) >> PH_DN);
  assign ph_c   = ph_s + QUARTER;
  assign a_est  = s4_prod[56:35];
  assign b_full = s4_m - 28'(28'(a_est) * 28'd125);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      vld <= '0;
    end else begin
      vld <= {vld[7:0], accept};
      unique case ({accept, pop})
        2'b10:   cnt <= cnt + CW'(1);
        2'b01:   cnt <= cnt - CW'(1);
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    // s1: capture and quadrant fold
    s1_vx  <= target_vx;
    s1_vy  <= target_vy;
    s1_w   <= target_turn;
    s1_lev <= base_mode ? half_perimeter_mm : {1'b0, center_distance_mm};
    s1_zs  <= quad_pos(ph_s);
    s1_zc  <= quad_pos(ph_c);
    s1_ns  <= ph_s[ANGLE_BITS-1];
    s1_nc  <= ph_c[ANGLE_BITS-1];
    md     <= {md[7:1], base_mode};
    // s2: z squared, turn lever product
    s2_vx  <= s1_vx;
    s2_vy  <= s1_vy;
    s2_zs  <= s1_zs;
    s2_zc  <= s1_zc;
    s2_ns  <= s1_ns;
    s2_nc  <= s1_nc;
    s2_z2s <= 17'((34'(s1_zs) * 34'(s1_zs) + 34'd32768) >> 16);
    s2_z2c <= 17'((34'(s1_zc) * 34'(s1_zc) + 34'd32768) >> 16);
    s2_wl  <= 30'(s1_w) * 30'($signed({1'b0, s1_lev}));
    // s3: inner polynomial term, lever magnitude
    s3_vx   <= s2_vx;
    s3_vy   <= s2_vy;
    s3_zs   <= s2_zs;
    s3_zc   <= s2_zc;
    s3_ns   <= s2_ns;
    s3_nc   <= s2_nc;
    s3_z2s  <= s2_z2s;
    s3_z2c  <= s2_z2c;
    s3_t1s  <= 16'(POLY_B - 32'((32'(POLY_C) * 32'(s2_z2s) + 32'd32768) >> 16));
    s3_t1c  <= 16'(POLY_B - 32'((32'(POLY_C) * 32'(s2_z2c) + 32'd32768) >> 16));
    s3_wneg <= s2_wl[29];
    s3_m    <= 28'(s2_wl[29] ? -s2_wl : s2_wl);
    // s4: middle polynomial term, reciprocal product
    s4_vx   <= s3_vx;
    s4_vy   <= s3_vy;
    s4_zs   <= s3_zs;
    s4_zc   <= s3_zc;
    s4_ns   <= s3_ns;
    s4_nc   <= s3_nc;
    s4_ts   <= 17'(POLY_A - 34'((34'(s3_z2s) * 34'(s3_t1s) + 34'd32768) >> 16));
    s4_tc   <= 17'(POLY_A - 34'((34'(s3_z2c) * 34'(s3_t1c) + 34'd32768) >> 16));
    s4_wneg <= s3_wneg;
    s4_m    <= s3_m;
    s4_prod <= 57'(s3_m) * 57'(RECIP_125);
    // s5: sine magnitude, quotient estimate
    s5_vx   <= s4_vx;
    s5_vy   <= s4_vy;
    s5_ns   <= s4_ns;
    s5_nc   <= s4_nc;
    s5_sm   <= 17'((34'(s4_zs) * 34'(s4_ts) + 34'd32768) >> 16);
    s5_cm   <= 17'((34'(s4_zc) * 34'(s4_tc) + 34'd32768) >> 16);
    s5_wneg <= s4_wneg;
    s5_a    <= a_est;
    s5_b    <= b_full[7:0];
    // s6: signs, quotient correction
    s6_vx   <= s5_vx;
    s6_vy   <= s5_vy;
    s6_s    <= s5_ns ? -$signed({1'b0, s5_sm}) : $signed({1'b0, s5_sm});
    s6_c    <= s5_nc ? -$signed({1'b0, s5_cm}) : $signed({1'b0, s5_cm});
    s6_wneg <= s5_wneg;
    if (s5_b >= 8'd125) begin
      s6_a <= s5_a + 22'd1;
      s6_b <= 7'(s5_b - 8'd125);
    end else begin
      s6_a <= s5_a;
      s6_b <= s5_b[6:0];
    end
    // s7: rotation products, turn magnitude
    s7_xc   <= 34'(s6_vx) * 34'(s6_c);
    s7_ys   <= 34'(s6_vy) * 34'(s6_s);
    s7_yc   <= 34'(s6_vy) * 34'(s6_c);
    s7_xs   <= 34'(s6_vx) * 34'(s6_s);
    s7_wneg <= s6_wneg;
    s7_tmag <= md[6] ? (34'(s6_a) << 12) + 34'(TURN_FRAC_MEC[s6_b])
                     : (34'(s6_a) << 13) + 34'(TURN_FRAC_OMNI[s6_b]);
    // s8: rotated velocity, signed turn
    s8_rvx  <= RW'(s7_xc) + RW'(s7_ys);
    s8_rvy  <= RW'(s7_yc) - RW'(s7_xs);
    s8_turn <= s7_wneg ? -$signed({1'b0, s7_tmag}) : $signed({1'b0, s7_tmag});
    // s9: omni sine product
    item.mode <= md[8];
    item.rvx  <= s8_rvx;
    item.rvy  <= s8_rvy;
    item.psin <= PW'(s8_rvx) * PW'(OMNI_SIN_Q16);
    item.turn <= s8_turn;
  end

endmodule

[rtl/cwk_queue.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// cwk_queue
// small fifo of prepared commands between intake and wheel issue
// ----------------------------------------------------------------------------
module cwk_queue import cwk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cwk_item_t  din,
  input  logic       pop,
  output cwk_item_t  head,
  output cwk_qstat_t stat
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  cwk_item_t   mem [QUEUE_DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;

  assign head       = mem[rp];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == (AW+1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + AW'(1);
      if (pop)  rp <= rp + AW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  `CWK_NEVER(a_no_overflow, clk, rst, push && stat.full)
  `CWK_NEVER(a_no_underflow, clk, rst, pop && stat.empty)
  `CWK_ASSERT(a_count_up, clk, rst, (push && !pop) |=> (count == $past(count) + 1'b1))

endmodule

[rtl/cwk_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwk_back
// per-wheel issue: wheel sum, turn term, rpm gain, rounding and saturation
// ----------------------------------------------------------------------------
module cwk_back import cwk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cwk_item_t          head,
  input  cwk_qstat_t         qstat,
  input  logic [23:0]        rpm_gain,
  output logic               pop,
  output logic               strobe,
  output logic [1:0]         wheel_index,
  output logic signed [15:0] wheel_rpm,
  output logic               last_wheel
);

  logic [1:0] widx;
  logic       issue, islast;
  logic [1:0] lastidx;
  logic signed [SW-1:0] sum_sel, rvx_e, rvy_e, ps_e;

  logic [5:0] vld;
  cwk_meta_t  meta [6];
  logic signed [SW-1:0] b1_sum;
  logic signed [TW-1:0] b1_turn, b2_turn;
  logic signed [VW-1:0] b2_lin, b3_v;
  logic signed [VW+12:0] b4_pl, b4_ph;
  logic signed [FW-1:0] b5_full, b6_x;
  logic signed [SW-1:0] rnd_sum;
  logic signed [FW-1:0] fin_sum;
  logic signed [30:0]   yq;

  assign lastidx = head.mode ? 2'd3 : 2'd2;
  assign issue   = !qstat.empty;
  assign islast  = (widx == lastidx);
  assign pop     = issue && islast;
  assign rvx_e   = SW'(head.rvx);
  assign rvy_e   = SW'(head.rvy);
  assign ps_e    = SW'(head.psin);

  always_comb begin
    if (head.mode) begin
      unique case (widx)
        2'd0: sum_sel = rvx_e + rvy_e;
        2'd1: sum_sel = rvx_e - rvy_e;
        2'd2: sum_sel = -rvx_e - rvy_e;
        2'd3: sum_sel = rvy_e - rvx_e;
      endcase
    end else begin
      unique case (widx)
        2'd1:    sum_sel = -ps_e - (rvy_e <<< 14);
        2'd2:    sum_sel = ps_e - (rvy_e <<< 14);
        default: sum_sel = rvy_e <<< 16;
      endcase
    end
  end

  assign rnd_sum = b1_sum + (b1_sum[SW-1] ? SW'(32767) : SW'(32768));
  assign fin_sum = b6_x + (b6_x[FW-1] ? FW'(64'd4294967295) : FW'(64'd4294967296));
  assign yq      = $signed(fin_sum[FW-1:33]);

  always_ff @(posedge clk) begin
    if (rst) begin
      widx   <= '0;
      vld    <= '0;
      strobe <= 1'b0;
    end else begin
      vld    <= {vld[4:0], issue};
      strobe <= vld[5];
      if (issue) widx <= islast ? 2'd0 : widx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    meta[0] <= '{mode: head.mode, idx: widx, last: islast};
    for (int i = 1; i < 6; i++) begin
      meta[i] <= meta[i-1];
    end
    b1_sum  <= sum_sel;
    b1_turn <= head.turn;
    b2_turn <= b1_turn;
    b2_lin  <= meta[0].mode ? VW'(b1_sum) : VW'($signed(rnd_sum[SW-1:16]));
    b3_v    <= meta[1].mode ? b2_lin - VW'(b2_turn) : b2_lin + VW'(b2_turn);
    b4_pl   <= (VW+13)'(b3_v) * (VW+13)'($signed({1'b0, rpm_gain[11:0]}));
    b4_ph   <= (VW+13)'(b3_v) * (VW+13)'($signed({1'b0, rpm_gain[23:12]}));
    b5_full <= (FW'(b4_ph) <<< 12) + FW'(b4_pl);
    b6_x    <= (b5_full <<< 1) + (meta[4].mode ? b5_full : FW'(0));
    wheel_index <= meta[5].idx;
    last_wheel  <= meta[5].last;
    if (yq > 31'sd32767) begin
      wheel_rpm <= 16'sh7FFF;
    end else if (yq < -31'sd32768) begin
      wheel_rpm <= 16'sh8000;
    end else begin
      wheel_rpm <= 16'(yq);
    end
  end

endmodule

[rtl/chassis_wheel_speed_kinematics_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chassis_wheel_speed_kinematics_unit
// world-frame velocity to per-wheel rpm for omni and mecanum bases
// ----------------------------------------------------------------------------
// usage:
//   a command (target_vx, target_vy, target_turn, heading) is taken on a
//   clock edge where start is high and busy is low.
//   results leave one wheel per cycle on wheel_index / wheel_rpm /
//   last_wheel, each marked by a one-cycle strobe; three wheels in omni
//   mode, four in mecanum mode, last_wheel set on the final one.
//   the first wheel passes the front stages s1 to s9, the queue, the back
//   stages b1 to b6 and the output register; the rest on the following cycles.
//   the command rate is set by the single wheel issue slot of the back end,
//   which takes a new command only after the last wheel of the one before;
//   up to eight commands may be in flight before busy rises.
//   configuration: cfg_index / cfg_data written when cfg_valid is high,
//   cfg_ready is always high; write only while no command is in flight.
//   reset: rst clears the pipelines and queue and loads the default
//   register values. the receiver cannot stall: every strobe is a transfer.
// ----------------------------------------------------------------------------
module chassis_wheel_speed_kinematics_unit import cwk_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] target_vx,
  input  logic signed [15:0] target_vy,
  input  logic signed [15:0] target_turn,
  input  logic [15:0]        heading,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output logic               strobe,
  output logic [1:0]         wheel_index,
  output logic signed [15:0] wheel_rpm,
  output logic               last_wheel
);

  logic        base_mode;
  logic [23:0] rpm_gain;
  logic [11:0] center_distance_mm;
  logic [12:0] half_perimeter_mm;

  logic       push, pop;
  cwk_item_t  item, head;
  cwk_qstat_t qstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_mode          <= 1'b0;
      rpm_gain           <= RPM_GAIN_RST;
      center_distance_mm <= CENTER_RST;
      half_perimeter_mm  <= HALF_PER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE_MODE: base_mode          <= cfg_data[0];
        REG_RPM_GAIN:  rpm_gain           <= cfg_data;
        REG_CENTER:    center_distance_mm <= cfg_data[11:0];
        REG_HALF_PER:  half_perimeter_mm  <= cfg_data[12:0];
      endcase
    end
  end

  cwk_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .target_vx          (target_vx),
    .target_vy          (target_vy),
    .target_turn        (target_turn),
    .heading            (heading),
    .base_mode          (base_mode),
    .center_distance_mm (center_distance_mm),
    .half_perimeter_mm  (half_perimeter_mm),
    .pop                (pop),
    .push               (push),
    .item               (item)
  );

  cwk_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (item),
    .pop  (pop),
    .head (head),
    .stat (qstat)
  );

  cwk_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .qstat       (qstat),
    .rpm_gain    (rpm_gain),
    .pop         (pop),
    .strobe      (strobe),
    .wheel_index (wheel_index),
    .wheel_rpm   (wheel_rpm),
    .last_wheel  (last_wheel)
  );

endmodule
